// ===== rtl/core/hbi2_pkg.sv =====
`timescale 1ns / 1ps

package hbi2_pkg;

  localparam int COEF_WIDTH    = 16;
  localparam int COEF_FRAC     = 15;
  localparam int NUM_COEF_REGS = 6;
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic [CFG_IDX_WIDTH-1:0]     cfg_idx_t;

  localparam cfg_idx_t CFG_COEF_0      = 3'd0;
  localparam cfg_idx_t CFG_MIDDLE_COEF = 3'd6;

  localparam coef_t MIDDLE_COEF_RESET = 16'sd16384;

endpackage

// ===== rtl/core/halfband_interpolator_by_two.sv =====
`timescale 1ns / 1ps

// Pipeline: the even-phase beat is valid once its input beat has passed the input,
// product, partial-sum and output pair registers; the odd-phase beat follows it.
// Throughput: one output beat every cycle while out_stall is low, and one input beat
// per two output beats, set by the two output beats drained from the output pair register.
// Reset (rst_n low, synchronous): pipeline empty, sample history zero,
// even coefficients zero, middle coefficient 0.5.
module halfband_interpolator_by_two #(
  parameter int EVEN_TAPS    = 6,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ODD_DELAY    = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  hbi2_pkg::cfg_idx_t                 cfg_index,
  input  logic [hbi2_pkg::COEF_WIDTH-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]     out_sample,
  output logic                               out_is_odd_phase
);
  import hbi2_pkg::*;

  localparam int HIST_DEPTH = ((EVEN_TAPS - 1) > ODD_DELAY) ? (EVEN_TAPS - 1) : ODD_DELAY;
  localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int GROUPS     = (EVEN_TAPS + 3) / 4;
  localparam int GSUM_W     = PROD_W + 2;
  localparam int ACC_W      = GSUM_W + 3;
  localparam int Q_W        = ACC_W + 1 - COEF_FRAC;

  localparam logic signed [ACC_W:0] HALF =
    {{(ACC_W - COEF_FRAC + 1){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
  localparam logic signed [Q_W-1:0] SMAX =
    Q_W'({1'b0, {(SAMPLE_WIDTH - 1){1'b1}}});
  localparam logic signed [Q_W-1:0] SMIN =
    Q_W'($signed({1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}));

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W:0] v;
    logic signed [Q_W-1:0] q;
    v = (ACC_W + 1)'(acc) + HALF;
    q = Q_W'(v >>> COEF_FRAC);
    if (q > SMAX) begin
      q = SMAX;
    end else if (q < SMIN) begin
      q = SMIN;
    end
    return q[SAMPLE_WIDTH-1:0];
  endfunction

  coef_t coef_r [NUM_COEF_REGS];
  coef_t middle_r;

  logic signed [SAMPLE_WIDTH-1:0] taps_r [HIST_DEPTH+1];
  logic signed [PROD_W-1:0]       prod_r [EVEN_TAPS];
  logic signed [PROD_W-1:0]       prod_nxt [EVEN_TAPS];
  logic signed [PROD_W-1:0]       podd_r;
  logic signed [PROD_W-1:0]       podd2_r;
  logic signed [GSUM_W-1:0]       gsum_r [GROUPS];
  logic signed [GSUM_W-1:0]       gsum_nxt [GROUPS];
  logic signed [ACC_W-1:0]        acc_nxt;
  logic signed [SAMPLE_WIDTH-1:0] even_r, odd_r;
  logic                           phase_r;
  logic                           v0_r, v1_r, v2_r, v3_r;
  logic                           rdy0, rdy1, rdy2, rdy3;
  logic                           in_take;

  assign rdy3     = !v3_r || (phase_r && !out_stall);
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;
  assign in_take  = in_valid && rdy0;

  assign out_valid        = v3_r;
  assign out_sample       = phase_r ? odd_r : even_r;
  assign out_is_odd_phase = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
        coef_r[i] <= '0;
      end
      middle_r <= MIDDLE_COEF_RESET;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_WIDTH'(NUM_COEF_REGS)) begin
        coef_r[cfg_index] <= coef_t'(cfg_data);
      end else if (cfg_index == CFG_MIDDLE_COEF) begin
        middle_r <= coef_t'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= HIST_DEPTH; i++) begin
        taps_r[i] <= '0;
      end
    end else if (in_take) begin
      taps_r[0] <= in_sample;
      for (int i = 1; i <= HIST_DEPTH; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < EVEN_TAPS; k++) begin : g_prod
    if (k < NUM_COEF_REGS) begin : g_mul
      assign prod_nxt[k] = PROD_W'(coef_r[k]) * PROD_W'(taps_r[k]);
    end else begin : g_zero
      assign prod_nxt[k] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gsum_nxt[g] = '0;
    end
    for (int k = 0; k < EVEN_TAPS; k++) begin
      gsum_nxt[k >> 2] = gsum_nxt[k >> 2] + GSUM_W'(prod_r[k]);
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      acc_nxt = acc_nxt + ACC_W'(gsum_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r    <= v2_r;
        phase_r <= 1'b0;
      end else if (!out_stall) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      prod_r <= prod_nxt;
      podd_r <= PROD_W'(middle_r) * PROD_W'(taps_r[ODD_DELAY]);
    end
    if (rdy2 && v1_r) begin
      gsum_r  <= gsum_nxt;
      podd2_r <= podd_r;
    end
    if (rdy3 && v2_r) begin
      even_r <= round_sat(acc_nxt);
      odd_r  <= round_sat(ACC_W'(podd2_r));
    end
  end

endmodule
